>>> rtl/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_OSS    = 3'd0,
        REG_AC1    = 3'd1,
        REG_AC2    = 3'd2,
        REG_AC3    = 3'd3,
        REG_AC4    = 3'd4,
        REG_B1B2   = 3'd5,
        REG_AC56   = 3'd6,
        REG_MCMD   = 3'd7
    } reg_idx_t;

    // serial multiplier handshake
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } mul_rsp_t;

    // serial divider handshake (unsigned)
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        // temperature
        ST_T_MUL,  ST_T_DEN, ST_T_DIV, ST_T_FIN,
        // pressure
        ST_P_SQ,   ST_P_SQ_W,
        ST_P_X1,   ST_P_X1_W,
        ST_P_X2,   ST_P_X2_W,
        ST_P_B3,
        ST_P_Y1,   ST_P_Y1_W,
        ST_P_Y2,   ST_P_Y2_W,
        ST_P_B4,   ST_P_B4_W,
        ST_P_B7,   ST_P_B7_W,
        ST_P_DIV,  ST_P_DIV_W,
        ST_P_Q1,   ST_P_Q1_W,
        ST_P_Q2,   ST_P_Q2_W,
        ST_P_Q3,   ST_P_Q3_W,
        ST_P_FIN,
        ST_OUT
    } state_t;

    localparam logic [WORD_W-1:0] C_4000  = 32'd4000;
    localparam logic [WORD_W-1:0] C_50000 = 32'd50000;
    localparam logic [WORD_W-1:0] C_HALF  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] C_32768 = 32'd32768;
    localparam logic [WORD_W-1:0] C_3038  = 32'd3038;
    localparam logic [WORD_W-1:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [WORD_W-1:0] C_3791  = 32'd3791;

    function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

>>> rtl/btpc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module btpc_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire btpc_pkg::mul_req_t req,
    output btpc_pkg::mul_rsp_t      rsp
);
    import btpc_pkg::*;

    logic [WORD_W-1:0] mcand_reg, mcand_next;
    logic [WORD_W-1:0] mplier_reg, mplier_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // shift-add, one multiplier bit per cycle, low 32 bits kept
    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            mcand_next  = req.a;
            mplier_next = req.b;
            acc_next    = '0;
            cnt_next    = 6'd0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[WORD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[WORD_W-1:1]};
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule
`default_nettype wire

>>> rtl/btpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module btpc_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire btpc_pkg::div_req_t req,
    output btpc_pkg::div_rsp_t      rsp
);
    import btpc_pkg::*;

    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WORD_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WORD_W]) begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule
`default_nettype wire

>>> rtl/barometer_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat contents
// s_axis    in   tdata[23:0] raw_reading, tuser action
// m_axis    out  tdata[31:0] value, tuser[0] kind, tuser[1] divide_error
// cfg       in   cfg_index register index, cfg_data write data
// One item at a time. Temperature takes one 32-step multiply and one 32-step divide;
// pressure takes ten multiplies and one divide,
// all through the bit-serial multiplier and divider.
// Synchronous active-low reset restores coefficients and clears the stored factor.
// The next item is taken once the result beat has moved to the output register.
module barometer_temp_pressure_compensation_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // raw_reading
    input  wire logic        s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // value
    output logic [1:0]       m_axis_tuser,   // kind, divide_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import btpc_pkg::*;

    logic [1:0]  oss_reg;
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg;
    logic [31:0] b1b2_reg, ac56_reg, mcmd_reg;
    logic [31:0] b5_reg, b5_next;

    state_t state_reg, state_next;
    logic        kind_reg, kind_next;
    logic [23:0] raw_reg, raw_next;
    logic [31:0] t0_reg, t0_next;   // den
    logic [31:0] t1_reg, t1_next;   // sq / misc
    logic [31:0] t2_reg, t2_next;   // b3
    logic [31:0] t3_reg, t3_next;   // accum / p
    logic [31:0] t4_reg, t4_next;   // b4
    logic        neg_reg, neg_next;
    logic        big_reg, big_next;
    logic        err_reg, err_next;
    logic [31:0] res_reg, res_next;

    logic        ov_reg, ov_next;
    logic [31:0] ov_data_reg, ov_data_next;
    logic [1:0]  ov_user_reg, ov_user_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    btpc_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    btpc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // configuration write
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oss_reg  <= 2'd0;
            ac1_reg  <= 16'd408;
            ac2_reg  <= 16'hFFB8;
            ac3_reg  <= 16'hC7D1;
            ac4_reg  <= 16'd32741;
            b1b2_reg <= 32'd405667844;
            ac56_reg <= 32'd2146785905;
            mcmd_reg <= 32'd3724086068;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_OSS:  oss_reg  <= cfg_data[1:0];
                REG_AC1:  ac1_reg  <= cfg_data[15:0];
                REG_AC2:  ac2_reg  <= cfg_data[15:0];
                REG_AC3:  ac3_reg  <= cfg_data[15:0];
                REG_AC4:  ac4_reg  <= cfg_data[15:0];
                REG_B1B2: b1b2_reg <= cfg_data;
                REG_AC56: ac56_reg <= cfg_data;
                REG_MCMD: mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac5, ac6, mc, md, b1, b2, ac1, ac2, ac3, ac4;
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign mc  = sx16(mcmd_reg[31:16]);
    assign md  = sx16(mcmd_reg[15:0]);
    assign b1  = sx16(b1b2_reg[31:16]);
    assign b2  = sx16(b1b2_reg[15:0]);
    assign ac1 = sx16(ac1_reg);
    assign ac2 = sx16(ac2_reg);
    assign ac3 = sx16(ac3_reg);
    assign ac4 = {16'd0, ac4_reg};

    logic [31:0] b6, up, mcs, dabs, nabs, b3_pre, x3s, p_asr8, qd;
    assign b6     = b5_reg - C_4000;
    assign up     = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
    assign mcs    = mc << 11;
    assign b3_pre = (((ac1 << 2) + t3_reg) << oss_reg) + 32'd2;
    assign x3s    = $signed(t3_reg + $unsigned($signed(mrsp.prod) >>> 16) + 32'd2) >>> 2;
    assign p_asr8 = $signed(t3_reg) >>> 8;
    assign dabs   = t0_reg[31] ? (32'd0 - t0_reg) : t0_reg;
    assign nabs   = mcs[31] ? (32'd0 - mcs) : mcs;
    assign qd     = drsp.quot;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_axis_tvalid && s_axis_tready)
                            state_next = s_axis_tuser ? ST_P_SQ : ST_T_MUL;
            ST_T_MUL:   if (mrsp.done) state_next = ST_T_DEN;
            ST_T_DEN:   state_next = ((t0_reg) == 32'd0) ? ST_OUT : ST_T_DIV;
            ST_T_DIV:   if (drsp.done) state_next = ST_T_FIN;
            ST_T_FIN:   state_next = ST_OUT;
            ST_P_SQ:    state_next = ST_P_SQ_W;
            ST_P_SQ_W:  if (mrsp.done) state_next = ST_P_X1;
            ST_P_X1:    state_next = ST_P_X1_W;
            ST_P_X1_W:  if (mrsp.done) state_next = ST_P_X2;
            ST_P_X2:    state_next = ST_P_X2_W;
            ST_P_X2_W:  if (mrsp.done) state_next = ST_P_B3;
            ST_P_B3:    state_next = ST_P_Y1;
            ST_P_Y1:    state_next = ST_P_Y1_W;
            ST_P_Y1_W:  if (mrsp.done) state_next = ST_P_Y2;
            ST_P_Y2:    state_next = ST_P_Y2_W;
            ST_P_Y2_W:  if (mrsp.done) state_next = ST_P_B4;
            ST_P_B4:    state_next = ST_P_B4_W;
            ST_P_B4_W:  if (mrsp.done) state_next = ST_P_B7;
            ST_P_B7:    state_next = ST_P_B7_W;
            ST_P_B7_W:  if (mrsp.done) state_next = ST_P_DIV;
            ST_P_DIV:   state_next = (t4_reg == 32'd0) ? ST_OUT : ST_P_DIV_W;
            ST_P_DIV_W: if (drsp.done) state_next = ST_P_Q1;
            ST_P_Q1:    state_next = ST_P_Q1_W;
            ST_P_Q1_W:  if (mrsp.done) state_next = ST_P_Q2;
            ST_P_Q2:    state_next = ST_P_Q2_W;
            ST_P_Q2_W:  if (mrsp.done) state_next = ST_P_Q3;
            ST_P_Q3:    state_next = ST_P_Q3_W;
            ST_P_Q3_W:  if (mrsp.done) state_next = ST_P_FIN;
            ST_P_FIN:   state_next = ST_OUT;
            ST_OUT:     if (!ov_reg) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and unit requests
    always_comb begin
        kind_next = kind_reg; raw_next = raw_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg;
        t3_next = t3_reg; t4_next = t4_reg;
        neg_next = neg_reg; big_next = big_reg; err_next = err_reg;
        res_next = res_reg; b5_next = b5_reg;
        mreq = '0; dreq = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    kind_next = s_axis_tuser;
                    raw_next  = s_axis_tdata;
                    err_next  = 1'b0;
                    res_next  = '0;
                    if (!s_axis_tuser) begin
                        mreq = '{start: 1'b1, a: {16'd0, s_axis_tdata[15:0]} - ac6, b: ac5};
                    end
                end
            end
            ST_T_MUL: if (mrsp.done) begin
                t1_next = $signed(mrsp.prod) >>> 15;                      // x1
                t0_next = $unsigned($signed(mrsp.prod) >>> 15) + md;      // den
            end
            ST_T_DEN: begin
                if (t0_reg == 32'd0) begin
                    err_next = 1'b1;
                end else begin
                    neg_next = t0_reg[31] ^ mcs[31];
                    dreq = '{start: 1'b1, num: nabs, den: dabs};
                end
            end
            ST_T_DIV: if (drsp.done) begin
                t2_next = neg_reg ? (32'd0 - qd) : qd;
            end
            ST_T_FIN: begin
                b5_next  = t1_reg + t2_reg;
                res_next = $signed(t1_reg + t2_reg + 32'd8) >>> 4;
            end
            ST_P_SQ:   mreq = '{start: 1'b1, a: b6, b: b6};
            ST_P_SQ_W: if (mrsp.done) t1_next = $signed(mrsp.prod) >>> 12;
            ST_P_X1:   mreq = '{start: 1'b1, a: b2, b: t1_reg};
            ST_P_X1_W: if (mrsp.done) t3_next = $signed(mrsp.prod) >>> 11;
            ST_P_X2:   mreq = '{start: 1'b1, a: ac2, b: b6};
            ST_P_X2_W: if (mrsp.done)
                           t3_next = t3_reg + $unsigned($signed(mrsp.prod) >>> 11);
            ST_P_B3:   t2_next = $signed(b3_pre) >>> 2;
            ST_P_Y1:   mreq = '{start: 1'b1, a: ac3, b: b6};
            ST_P_Y1_W: if (mrsp.done) t3_next = $signed(mrsp.prod) >>> 13;
            ST_P_Y2:   mreq = '{start: 1'b1, a: b1, b: t1_reg};
            ST_P_Y2_W: if (mrsp.done) t3_next = x3s;
            ST_P_B4:   mreq = '{start: 1'b1, a: ac4, b: t3_reg + C_32768};
            ST_P_B4_W: if (mrsp.done) t4_next = mrsp.prod >> 15;
            ST_P_B7:   mreq = '{start: 1'b1, a: up - t2_reg, b: C_50000 >> oss_reg};
            ST_P_B7_W: if (mrsp.done) t3_next = mrsp.prod;
            ST_P_DIV: begin
                if (t4_reg == 32'd0) begin
                    err_next = 1'b1;
                end else begin
                    big_next = (t3_reg >= C_HALF);
                    dreq = '{start: 1'b1,
                             num: (t3_reg < C_HALF) ? (t3_reg << 1) : t3_reg,
                             den: t4_reg};
                end
            end
            ST_P_DIV_W: if (drsp.done) t3_next = big_reg ? (qd << 1) : qd;
            ST_P_Q1:   mreq = '{start: 1'b1, a: p_asr8, b: p_asr8};
            ST_P_Q1_W: if (mrsp.done) t1_next = mrsp.prod;
            ST_P_Q2:   mreq = '{start: 1'b1, a: t1_reg, b: C_3038};
            ST_P_Q2_W: if (mrsp.done) t1_next = $signed(mrsp.prod) >>> 16;
            ST_P_Q3:   mreq = '{start: 1'b1, a: C_M7357, b: t3_reg};
            ST_P_Q3_W: if (mrsp.done) t2_next = $signed(mrsp.prod) >>> 16;
            ST_P_FIN:  res_next = t3_reg
                                  + $unsigned($signed(t1_reg + t2_reg + C_3791) >>> 4);
            ST_OUT: ;
            default: ;
        endcase
    end

    // output register
    always_comb begin
        ov_next = ov_reg; ov_data_next = ov_data_reg; ov_user_next = ov_user_reg;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        if (state_reg == ST_OUT && !ov_reg) begin
            ov_next      = 1'b1;
            ov_data_next = res_reg;
            ov_user_next = {err_reg, kind_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            b5_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            b5_reg    <= b5_next;
        end
        kind_reg <= kind_next; raw_reg <= raw_next;
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next;
        t3_reg <= t3_next; t4_reg <= t4_next;
        neg_reg <= neg_next; big_reg <= big_next; err_reg <= err_next;
        res_reg <= res_next;
        ov_data_reg <= ov_data_next; ov_user_reg <= ov_user_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = ov_data_reg;
    assign m_axis_tuser  = ov_user_reg;

`ifndef SYNTH
    // an error beat always carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 32'd0))
        else $error("error beat with nonzero value");
    // the stored factor changes only when a temperature finishes
    a_b5_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_T_FIN) |=> $stable(b5_reg))
        else $error("temperature factor changed unexpectedly");
    // no new item while a computation is in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
`endif
endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import btpc_pkg::*;

    // one reading and one compensated result
    typedef struct packed {
        logic        action;
        logic [23:0] raw;
    } reading_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        div_err;
    } comp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    barometer_temp_pressure_compensation_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow registers and stored temperature factor
    logic [1:0]  oss_q;
    logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
    logic [31:0] b1b2_q, ac56_q, mcmd_q, b5_q;

    reading_t pending_q[$];
    comp_t    expected_q[$];
    int  n_errors = 0;
    int  n_results = 0;
    int  n_temp = 0, n_press = 0, n_derr = 0;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;
    bit  sink_hold = 1'b0;
    int  sink_hold_cnt = 0;
    bit  stim_done = 1'b0;
    bit  in_taken = 1'b0;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] d);
        logic [31:0] ma, md, q;
        ma = a[31] ? -a : a;
        md = d[31] ? -d : d;
        q = ma / md;
        return (a[31] != d[31]) ? -q : q;
    endfunction

    // compensate one reading; a temperature without divide error also updates the stored factor
    function automatic comp_t compensate(input reading_t r);
        comp_t c;
        logic [31:0] ut, x1, x2, x3, den, up, b6, sq, b3, b4, b7, p;
        int sh;
        c.kind = r.action;
        c.value = '0;
        c.div_err = 1'b0;
        if (r.action == 1'b0) begin
            ut = {16'h0, r.raw[15:0]};
            x1 = sra((ut - {16'h0, ac56_q[15:0]}) * {16'h0, ac56_q[31:16]}, 15);
            den = x1 + sext16(mcmd_q[15:0]);
            if (den == 0) begin
                c.div_err = 1'b1;
            end else begin
                x2 = div_trunc(sext16(mcmd_q[31:16]) << 11, den);
                b5_q = x1 + x2;
                c.value = sra(b5_q + 32'd8, 4);
            end
        end else begin
            sh = oss_q;
            up = {8'h0, r.raw} >> (8 - sh);
            b6 = b5_q - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(sext16(b1b2_q[15:0]) * sq, 11);
            x2 = sra(sext16(ac2_q) * b6, 11);
            x3 = x1 + x2;
            b3 = sra(((sext16(ac1_q) * 32'd4 + x3) << sh) + 32'd2, 2);
            x1 = sra(sext16(ac3_q) * b6, 13);
            x2 = sra(sext16(b1b2_q[31:16]) * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = ({16'h0, ac4_q} * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> sh);
            if (b4 == 0) begin
                c.div_err = 1'b1;
            end else begin
                p = (b7 < 32'h8000_0000) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
                x1 = sra(p, 8) * sra(p, 8);
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra(-32'd7357 * p, 16);
                c.value = p + sra(x1 + x2 + 32'd3791, 4);
            end
        end
        return c;
    endfunction

    // mark an input beat taken at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
    end

    // driver: offer queued readings, random gaps while idling is enabled
    int src_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_q[0].action;
                    s_axis_tdata <= pending_q[0].raw;
                    void'(pending_q.pop_front());
                    if (src_idle_en && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 6);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            expected_q.push_back(compensate('{action: s_axis_tuser, raw: s_axis_tdata}));
        end
    end

    // receiver stalls; a long hold is counted here in cycles
    int sink_gap = 0;
    always @(negedge aclk) begin
        if (sink_hold && sink_hold_cnt < 2000) begin
            sink_hold_cnt <= sink_hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            sink_gap <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        comp_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: value %h tuser %b", m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.kind) n_press++; else n_temp++;
                if (exp_r.div_err) n_derr++;
                if (m_axis_tuser[0] !== exp_r.kind) begin
                    $error("kind: expected %0d actual %0d", exp_r.kind, m_axis_tuser[0]);
                    n_errors++;
                end
                if (m_axis_tdata !== exp_r.value) begin
                    $error("value: expected %0d actual %0d",
                           $signed(exp_r.value), $signed(m_axis_tdata));
                    n_errors++;
                end
                if (m_axis_tuser[1] !== exp_r.div_err) begin
                    $error("divide_error: expected %0d actual %0d",
                           exp_r.div_err, m_axis_tuser[1]);
                    n_errors++;
                end
            end
        end
    end

    task automatic wait_drain();
        while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // write one register while idle, mirror it into the shadow copy
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_OSS:  oss_q = val[1:0];
            REG_AC1:  ac1_q = val[15:0];
            REG_AC2:  ac2_q = val[15:0];
            REG_AC3:  ac3_q = val[15:0];
            REG_AC4:  ac4_q = val[15:0];
            REG_B1B2: b1b2_q = val;
            REG_AC56: ac56_q = val;
            REG_MCMD: mcmd_q = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(input logic act, input logic [23:0] raw);
        reading_t r;
        r.action = act;
        r.raw = raw;
        pending_q.push_back(r);
    endtask

    // mostly temperature then pressure pairs, with raw words near typical levels
    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: push_item(1'b0, 24'($urandom));
                1: push_item(1'b1, 24'($urandom));
                default: begin
                    push_item(1'b0, {8'($urandom_range(0, 255)),
                                     16'($urandom_range(20000, 32000))});
                    push_item(1'b1, {16'($urandom_range(20000, 45000)),
                                     8'($urandom_range(0, 255))});
                    i++;
                end
            endcase
        end
    endtask

    task automatic random_coefs();
        write_reg(REG_OSS, $urandom);
        write_reg(REG_AC1, $urandom);
        write_reg(REG_AC2, $urandom);
        write_reg(REG_AC3, $urandom);
        write_reg(REG_AC4, $urandom);
        write_reg(REG_B1B2, $urandom);
        write_reg(REG_AC56, $urandom);
        write_reg(REG_MCMD, $urandom);
    endtask

    initial begin
        oss_q = 2'd0;
        ac1_q = 16'd408;
        ac2_q = -16'sd72;
        ac3_q = -16'sd14383;
        ac4_q = 16'd32741;
        b1b2_q = 32'd405667844;
        ac56_q = 32'd2146785905;
        mcmd_q = 32'd3724086068;
        b5_q = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: pressure before any temperature, reset coefficients
        push_item(1'b1, 24'd0);
        push_item(1'b1, 24'hFFFFFF);
        push_item(1'b0, 24'd27898);
        push_item(1'b1, 24'd23843 << 8);
        push_item(1'b0, 24'hFF0000);
        push_item(1'b0, 24'h00FFFF);
        push_item(1'b0, 24'hAAAAAA);
        push_item(1'b1, 24'h555555);
        wait_drain();

        // MD = 0 first; with AC5 = 0 below, X1 = 0 gives a zero temperature divisor
        write_reg(REG_MCMD, 32'h1234_0000);
        push_item(1'b0, 24'd1000);
        wait_drain();
        // zero pressure divisor: AC4 = 0
        write_reg(REG_AC4, 32'hFFFF_0000);
        wait_drain();
        write_reg(REG_AC56, 32'h0000_1234);
        write_reg(REG_MCMD, 32'h1234_0000);
        push_item(1'b0, 24'd1000);
        push_item(1'b1, 24'd5000000);
        wait_drain();

        // extremes of every register and every oversampling step
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_OSS, k);
            write_reg(REG_AC1, k[0] ? 32'h8000 : 32'h7FFF);
            write_reg(REG_AC2, k[1] ? 32'h8000 : 32'h7FFF);
            write_reg(REG_AC3, k[0] ? 32'h7FFF : 32'h8000);
            write_reg(REG_AC4, k[1] ? 32'hFFFF : 32'h0001);
            write_reg(REG_B1B2, k[0] ? 32'h8000_7FFF : 32'h7FFF_8000);
            write_reg(REG_AC56, k[1] ? 32'hFFFF_FFFF : 32'h0001_0000);
            write_reg(REG_MCMD, k[0] ? 32'h8000_8000 : 32'h7FFF_7FFF);
            push_item(1'b0, 24'hFFFFFF);
            push_item(1'b1, 24'hFFFFFF);
            push_item(1'b0, 24'h000000);
            push_item(1'b1, 24'h000001);
            wait_drain();
        end

        // back to typical coefficients, random phases
        write_reg(REG_OSS, 32'd3);
        write_reg(REG_AC1, 32'd408);
        write_reg(REG_AC2, 32'hFFB8);
        write_reg(REG_AC3, 32'hC7D1);
        write_reg(REG_AC4, 32'd32741);
        write_reg(REG_B1B2, 32'd405667844);
        write_reg(REG_AC56, 32'd2146785905);
        write_reg(REG_MCMD, 32'd3724086068);
        push_random(300);

        // long receiver hold while the sender keeps offering
        sink_hold = 1'b1;
        wait (sink_hold_cnt >= 2000);
        sink_hold = 1'b0;
        wait_drain();

        random_coefs();
        push_random(300);
        wait_drain();
        write_reg(REG_OSS, 32'd1);
        push_random(250);
        wait_drain();

        // last part without idling
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        random_coefs();
        push_random(200);
        wait_drain();
        stim_done = 1'b1;

        $display("Checked %0d results: %0d temperature, %0d pressure, %0d divide errors,",
                 n_results, n_temp, n_press, n_derr);
        $display("across reset, extreme and random coefficient sets at all oversampling steps.");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/btpc_pkg.sv
rtl/btpc_mul.sv
rtl/btpc_div.sv
rtl/barometer_temp_pressure_compensation_unit.sv
test/tb_top.sv
